// ----- design/md5_pkg.sv -----
// md5 hasher package: beat types, chaining constants and round tables
`default_nettype none
package md5_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word0;
        logic [31:0] digest_word1;
        logic [31:0] digest_word2;
        logic [31:0] digest_word3;
    } t_out;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_abcd;

    typedef struct packed {
        logic [5:0]  rnd;
        t_abcd       work;
        logic [31:0] msg_word;
    } t_round_in;

    localparam logic        KIND_DATA   = 1'b0;
    localparam logic        KIND_FINISH = 1'b1;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam t_abcd       IV   = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};

    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam logic [6:0]  LEN_POS  = 7'd56;

    function automatic logic [31:0] round_const(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] msg_idx(input logic [5:0] r);
        logic [3:0] lo;
        logic [3:0] idx;
        lo = r[3:0];
        case (r[5:4])
            2'd0:    idx = lo;
            2'd1:    idx = 4'(lo * 4'd5 + 4'd1);
            2'd2:    idx = 4'(lo * 4'd3 + 4'd5);
            default: idx = 4'(lo * 4'd7);
        endcase
        return idx;
    endfunction

endpackage
`default_nettype wire

// ----- design/md5_round.sv -----
// md5 shared round unit: one step of the compression per cycle
`default_nettype none
module md5_round (
    input  wire md5_pkg::t_round_in i_rin,
    output md5_pkg::t_abcd          o_work
);

    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] rot;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;

    assign b = i_rin.work.b;
    assign c = i_rin.work.c;
    assign d = i_rin.work.d;

    always_comb begin
        case (i_rin.rnd[5:4])
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (d & b) | (~d & c);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
    end

    assign sum = i_rin.work.a + f + md5_pkg::round_const(i_rin.rnd) + i_rin.msg_word;
    assign rot = {sum, sum} << md5_pkg::rot_amt(i_rin.rnd);

    assign o_work.a = d;
    assign o_work.b = b + rot[63:32];
    assign o_work.c = b;
    assign o_work.d = c;

endmodule
`default_nettype wire

// ----- design/md5_message_hasher.sv -----
// md5 message hasher top level: byte buffer, padding sequencer and chaining state
//
//   channel | direction | handshake                     | payload
//   input   | in        | i_in_valid / o_in_ready       | i_in_data    (t_in)
//   output  | out       | o_out_valid / i_out_ready     | o_out_digest (t_out)
//
// a data beat is stored in the buffer; a beat that fills the block starts 64 rounds and the add
// a finish beat writes the pad mark, pads out the block and compresses it, with a second
// padding pass and compression when fill is 56 or more, then loads the output register
// ready is low while padding or compressing; a waiting digest holds the block in emit
// synchronous active-low reset restores the initial chaining words and empties the buffer
`default_nettype none
module md5_message_hasher (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire md5_pkg::t_in   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output md5_pkg::t_out       o_out_digest
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [5:0]       r_rnd, n_rnd;
    logic [6:0]       r_pos, n_pos;
    logic [5:0]       r_fill, n_fill;
    logic [63:0]      r_count, n_count;
    logic             r_two, n_two;
    logic             r_fin, n_fin;
    md5_pkg::t_abcd   r_h, n_h;
    md5_pkg::t_abcd   r_work, n_work;
    md5_pkg::t_out    r_out, n_out;
    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_buf [16];

    logic             in_acc;
    logic             wr_en;
    logic [5:0]       wr_addr;
    logic [7:0]       wr_byte;
    logic [63:0]      bit_len;
    md5_pkg::t_round_in rin;
    md5_pkg::t_abcd   rnd_out;

    assign in_acc  = i_in_valid && o_in_ready;
    assign bit_len = {r_count[60:0], 3'b000};

    assign rin.rnd      = r_rnd;
    assign rin.work     = r_work;
    assign rin.msg_word = r_buf[md5_pkg::msg_idx(r_rnd)];

    md5_round u_round (
        .i_rin  (rin),
        .o_work (rnd_out)
    );

    always_comb begin
        n_state     = r_state;
        n_rnd       = r_rnd;
        n_pos       = r_pos;
        n_fill      = r_fill;
        n_count     = r_count;
        n_two       = r_two;
        n_fin       = r_fin;
        n_h         = r_h;
        n_work      = r_work;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        wr_en       = 1'b0;
        wr_addr     = r_fill;
        wr_byte     = i_in_data.data_byte;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    wr_en = 1'b1;
                    if (i_in_data.kind == md5_pkg::KIND_DATA) begin
                        n_fill  = r_fill + 6'd1;
                        n_count = r_count + 64'd1;
                        if (r_fill == 6'd63) begin
                            n_state = ST_ROUND;
                            n_rnd   = '0;
                            n_work  = r_h;
                        end
                    end else begin
                        wr_byte = md5_pkg::PAD_MARK;
                        n_fin   = 1'b1;
                        n_two   = (r_fill[5:3] == 3'b111);
                        n_pos   = {1'b0, r_fill} + 7'd1;
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (r_pos[6]) begin
                    n_state = ST_ROUND;
                    n_rnd   = '0;
                    n_work  = r_h;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_pos[5:0];
                    if (r_pos < md5_pkg::LEN_POS || r_two) begin
                        wr_byte = 8'h00;
                    end else begin
                        wr_byte = bit_len[{r_pos[2:0], 3'b000} +: 8];
                    end
                    n_pos = r_pos + 7'd1;
                end
            end
            ST_ROUND: begin
                n_work = rnd_out;
                n_rnd  = r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_h.a = r_h.a + r_work.a;
                n_h.b = r_h.b + r_work.b;
                n_h.c = r_h.c + r_work.c;
                n_h.d = r_h.d + r_work.d;
                if (!r_fin) begin
                    n_state = ST_IDLE;
                end else if (r_two) begin
                    n_two   = 1'b0;
                    n_pos   = '0;
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.digest_word0 = r_h.a;
                    n_out.digest_word1 = r_h.b;
                    n_out.digest_word2 = r_h.c;
                    n_out.digest_word3 = r_h.d;
                    n_out_valid = 1'b1;
                    n_h         = md5_pkg::IV;
                    n_fill      = '0;
                    n_count     = '0;
                    n_fin       = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rnd       <= '0;
            r_pos       <= '0;
            r_fill      <= '0;
            r_count     <= '0;
            r_two       <= 1'b0;
            r_fin       <= 1'b0;
            r_h         <= md5_pkg::IV;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rnd       <= n_rnd;
            r_pos       <= n_pos;
            r_fill      <= n_fill;
            r_count     <= n_count;
            r_two       <= n_two;
            r_fin       <= n_fin;
            r_h         <= n_h;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_out  <= n_out;
        if (wr_en) begin
            r_buf[wr_addr[5:2]][{wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
        end
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_digest = r_out;

endmodule
`default_nettype wire

// ----- design/md5_checker.sv -----
// md5 hasher port checker and its bind to the top level
`default_nettype none
module md5_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_in_valid,
    input wire                o_in_ready,
    input wire md5_pkg::t_in  i_in_data,
    input wire                o_out_valid,
    input wire                i_out_ready,
    input wire md5_pkg::t_out o_out_digest
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_digest))
        else $error("digest beat dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("digest beat present after reset");

    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.kind == md5_pkg::KIND_FINISH
        |=> !o_in_ready && !$rose(o_out_valid))
        else $error("finish beat did not start padding");

    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("digest appeared while input side was open");

endmodule

bind md5_message_hasher md5_checker u_md5_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_in_data    (i_in_data),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_digest (o_out_digest)
);
`default_nettype wire
